@@ rtl/core/oar_pkg.sv @@
package oar_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int BYTE_BITS     = 8;

    localparam logic [3:0] AM_IMM  = 4'd0;
    localparam logic [3:0] AM_ZP   = 4'd1;
    localparam logic [3:0] AM_ZPX  = 4'd2;
    localparam logic [3:0] AM_ZPY  = 4'd3;
    localparam logic [3:0] AM_ABS  = 4'd4;
    localparam logic [3:0] AM_ABSX = 4'd5;
    localparam logic [3:0] AM_ABSY = 4'd6;
    localparam logic [3:0] AM_IND  = 4'd7;
    localparam logic [3:0] AM_INDX = 4'd8;
    localparam logic [3:0] AM_INDY = 4'd9;
    localparam logic [3:0] AM_REL  = 4'd10;

    localparam logic MODE_WRITE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPLO,
        ST_OPHI,
        ST_PLO,
        ST_PHI,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctrl_t;

endpackage

@@ rtl/core/operand_address_resolver.sv @@
// Write, immediate, relative and unknown modes go straight to the result; zero page
// modes read one operand byte, absolute modes two, indexed indirect and indirect indexed
// one operand byte and two pointer bytes, indirect two of each. One request is in work
// at a time, and each memory byte is read on the single read port. The result register
// lets the next request start while a result waits. Reset (aresetn low, synchronous)
// clears control state only; memory stays undefined.
module operand_address_resolver
    import oar_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [3:0]            s_addressing_mode,
    input  logic [ADDR_BITS-1:0]  s_pc,
    input  logic [BYTE_BITS-1:0]  s_index_x,
    input  logic [BYTE_BITS-1:0]  s_index_y,
    input  logic [ADDR_BITS-1:0]  s_write_address,
    input  logic [BYTE_BITS-1:0]  s_write_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_BITS-1:0]  m_effective_address,
    output logic [ADDR_BITS-1:0]  m_next_pc,
    output logic                  m_mode_error
);

    localparam int HI_BITS = ADDR_BITS - BYTE_BITS;
    localparam logic [ADDR_BITS-1:0] ONE = ADDR_BITS'(1);
    localparam logic [ADDR_BITS-1:0] TWO = ADDR_BITS'(2);

    state_t               state_reg, state_next;
    logic [3:0]           am_reg, am_next;
    logic [BYTE_BITS-1:0] x_reg, x_next;
    logic [BYTE_BITS-1:0] y_reg, y_next;
    logic [ADDR_BITS-1:0] pc_reg, pc_next;
    logic [ADDR_BITS-1:0] npc_reg, npc_next;
    logic [BYTE_BITS-1:0] byte_reg, byte_next;
    logic [ADDR_BITS-1:0] ptr_reg, ptr_next;
    logic [ADDR_BITS-1:0] ea_reg, ea_next;
    logic                 err_reg, err_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ADDR_BITS-1:0] m_ea_reg, m_ea_next;
    logic [ADDR_BITS-1:0] m_npc_reg, m_npc_next;
    logic                 m_err_reg, m_err_next;

    mem_ctrl_t            mem_ctrl;
    logic [ADDR_BITS-1:0] raddr;
    logic [BYTE_BITS-1:0] rdata;
    logic [ADDR_BITS-1:0] op16;
    logic [ADDR_BITS-1:0] ptr_hi_addr;
    logic                 accept;
    logic                 out_free;

    oar_mem #(
        .ADDR_BITS (ADDR_BITS)
    ) u_mem (
        .aclk  (aclk),
        .ctrl  (mem_ctrl),
        .waddr (s_write_address),
        .wdata (s_write_data),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign op16     = ADDR_BITS'({rdata, byte_reg});
    // high pointer byte stays in the pointer's page
    assign ptr_hi_addr = {ptr_reg[ADDR_BITS-1:BYTE_BITS], ptr_reg[BYTE_BITS-1:0] + 8'd1};

    always_comb begin
        state_next  = state_reg;
        am_next     = am_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        pc_next     = pc_reg;
        npc_next    = npc_reg;
        byte_next   = byte_reg;
        ptr_next    = ptr_reg;
        ea_next     = ea_reg;
        err_next    = err_reg;
        mem_ctrl.we = 1'b0;
        mem_ctrl.re = 1'b0;
        raddr       = s_pc;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    am_next  = s_addressing_mode;
                    x_next   = s_index_x;
                    y_next   = s_index_y;
                    pc_next  = s_pc;
                    ea_next  = '0;
                    err_next = 1'b0;
                    if (s_mode == MODE_WRITE) begin
                        mem_ctrl.we = 1'b1;
                        npc_next    = '0;
                        state_next  = ST_DONE;
                    end else begin
                        case (s_addressing_mode)
                            AM_IMM, AM_REL: begin
                                ea_next    = s_pc;
                                npc_next   = s_pc + ONE;
                                state_next = ST_DONE;
                            end
                            AM_ZP, AM_ZPX, AM_ZPY, AM_INDX, AM_INDY: begin
                                mem_ctrl.re = 1'b1;
                                npc_next    = s_pc + ONE;
                                state_next  = ST_OPLO;
                            end
                            AM_ABS, AM_ABSX, AM_ABSY, AM_IND: begin
                                mem_ctrl.re = 1'b1;
                                npc_next    = s_pc + TWO;
                                state_next  = ST_OPLO;
                            end
                            default: begin
                                npc_next   = s_pc;
                                err_next   = 1'b1;
                                state_next = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            ST_OPLO: begin
                byte_next = rdata;
                case (am_reg)
                    AM_ZP: begin
                        ea_next    = {{HI_BITS{1'b0}}, rdata};
                        state_next = ST_DONE;
                    end
                    AM_ZPX: begin
                        ea_next    = {{HI_BITS{1'b0}}, rdata + x_reg};
                        state_next = ST_DONE;
                    end
                    AM_ZPY: begin
                        ea_next    = {{HI_BITS{1'b0}}, rdata + y_reg};
                        state_next = ST_DONE;
                    end
                    AM_INDX: begin
                        ptr_next    = {{HI_BITS{1'b0}}, rdata + x_reg};
                        raddr       = ptr_next;
                        mem_ctrl.re = 1'b1;
                        state_next  = ST_PLO;
                    end
                    AM_INDY: begin
                        ptr_next    = {{HI_BITS{1'b0}}, rdata};
                        raddr       = ptr_next;
                        mem_ctrl.re = 1'b1;
                        state_next  = ST_PLO;
                    end
                    default: begin
                        raddr       = pc_reg + ONE;
                        mem_ctrl.re = 1'b1;
                        state_next  = ST_OPHI;
                    end
                endcase
            end
            ST_OPHI: begin
                case (am_reg)
                    AM_ABSX: begin
                        ea_next    = op16 + {{HI_BITS{1'b0}}, x_reg};
                        state_next = ST_DONE;
                    end
                    AM_ABSY: begin
                        ea_next    = op16 + {{HI_BITS{1'b0}}, y_reg};
                        state_next = ST_DONE;
                    end
                    AM_IND: begin
                        ptr_next    = op16;
                        raddr       = op16;
                        mem_ctrl.re = 1'b1;
                        state_next  = ST_PLO;
                    end
                    default: begin
                        ea_next    = op16;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PLO: begin
                byte_next   = rdata;
                raddr       = ptr_hi_addr;
                mem_ctrl.re = 1'b1;
                state_next  = ST_PHI;
            end
            ST_PHI: begin
                if (am_reg == AM_INDY) begin
                    ea_next = op16 + {{HI_BITS{1'b0}}, y_reg};
                end else begin
                    ea_next = op16;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register frees up
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_ea_next    = m_ea_reg;
        m_npc_next   = m_npc_reg;
        m_err_next   = m_err_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next = 1'b1;
            m_ea_next    = ea_reg;
            m_npc_next   = npc_reg;
            m_err_next   = err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        am_reg    <= am_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        pc_reg    <= pc_next;
        npc_reg   <= npc_next;
        byte_reg  <= byte_next;
        ptr_reg   <= ptr_next;
        ea_reg    <= ea_next;
        err_reg   <= err_next;
        m_ea_reg  <= m_ea_next;
        m_npc_reg <= m_npc_next;
        m_err_reg <= m_err_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_effective_address = m_ea_reg;
    assign m_next_pc           = m_npc_reg;
    assign m_mode_error        = m_err_reg;

endmodule

@@ rtl/core/oar_mem.sv @@
module oar_mem
    import oar_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  mem_ctrl_t             ctrl,
    input  logic [ADDR_BITS-1:0]  waddr,
    input  logic [BYTE_BITS-1:0]  wdata,
    input  logic [ADDR_BITS-1:0]  raddr,
    output logic [BYTE_BITS-1:0]  rdata
);

    logic [BYTE_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [BYTE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[waddr] <= wdata;
        end
        if (ctrl.re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ dv/operand_address_checker.sv @@
`timescale 1ns / 1ps

module operand_address_checker
    import oar_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [3:0]  s_addressing_mode,
    input  logic [15:0] s_pc,
    input  logic [7:0]  s_index_x,
    input  logic [7:0]  s_index_y,
    input  logic [15:0] s_write_address,
    input  logic [7:0]  s_write_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_effective_address,
    input  logic [15:0] m_next_pc,
    input  logic        m_mode_error,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] effective_address;
        logic [15:0] next_pc;
        logic        mode_error;
    } address_result_t;

    logic [7:0]      byte_store [0:65535];
    address_result_t expected_addresses [$];

    function automatic address_result_t resolve_operand(
        input logic [3:0]  am,
        input logic [15:0] pc,
        input logic [7:0]  ix,
        input logic [7:0]  iy
    );
        address_result_t r;
        logic [15:0]     base;
        logic [15:0]     ptr_lo;
        logic [15:0]     ptr_hi;
        logic [7:0]      zp;
        logic [7:0]      zp_next;
        r.effective_address = '0;
        r.next_pc           = pc + 16'd1;
        r.mode_error        = 1'b0;
        base                = {byte_store[pc + 16'd1], byte_store[pc]};
        case (am)
            AM_IMM, AM_REL: r.effective_address = pc;
            AM_ZP: r.effective_address = {8'h00, byte_store[pc]};
            AM_ZPX: begin
                zp = byte_store[pc] + ix;
                r.effective_address = {8'h00, zp};
            end
            AM_ZPY: begin
                zp = byte_store[pc] + iy;
                r.effective_address = {8'h00, zp};
            end
            AM_ABS, AM_ABSX, AM_ABSY: begin
                r.next_pc = pc + 16'd2;
                if (am == AM_ABSX)
                    r.effective_address = base + {8'h00, ix};
                else if (am == AM_ABSY)
                    r.effective_address = base + {8'h00, iy};
                else
                    r.effective_address = base;
            end
            AM_IND: begin
                // high pointer byte stays in the pointer's page
                ptr_lo = base;
                ptr_hi = {base[15:8], base[7:0] + 8'd1};
                r.effective_address = {byte_store[ptr_hi], byte_store[ptr_lo]};
                r.next_pc = pc + 16'd2;
            end
            AM_INDX, AM_INDY: begin
                zp = (am == AM_INDX) ? byte_store[pc] + ix : byte_store[pc];
                zp_next = zp + 8'd1;
                r.effective_address = {byte_store[{8'h00, zp_next}], byte_store[{8'h00, zp}]};
                if (am == AM_INDY)
                    r.effective_address = r.effective_address + {8'h00, iy};
            end
            default: begin
                r.next_pc    = pc;
                r.mode_error = 1'b1;
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        address_result_t want;
        if (aresetn) begin
            // retire first, so a result can never match a request taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_addresses.size() == 0) begin
                    $display("%0t: unexpected result ea %h next_pc %h err %b", $time,
                             m_effective_address, m_next_pc, m_mode_error);
                    fail_count++;
                end else begin
                    want = expected_addresses.pop_front();
                    if ({m_effective_address, m_next_pc, m_mode_error} !== want) begin
                        $display("%0t: expected ea %h next_pc %h err %b, got ea %h next_pc %h err %b",
                                 $time, want.effective_address, want.next_pc, want.mode_error,
                                 m_effective_address, m_next_pc, m_mode_error);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_mode == MODE_WRITE) begin
                    byte_store[s_write_address] = s_write_data;
                    expected_addresses.push_back('0);
                end else begin
                    expected_addresses.push_back(resolve_operand(s_addressing_mode, s_pc,
                                                                 s_index_x, s_index_y));
                end
            end
        end
        pending = expected_addresses.size();
    end

endmodule

@@ dv/operand_address_resolver_test.sv @@
`timescale 1ns / 1ps

module operand_address_resolver_test;
    import oar_pkg::*;

    localparam logic       MODE_RESOLVE    = ~MODE_WRITE;
    localparam logic [3:0] AM_NONE         = AM_REL + 4'd1;
    localparam logic [3:0] AM_LAST_CODE    = 4'hF;
    localparam int         TARGET_REQUESTS = 550;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         STALL_LIMIT     = 3000;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_HALF,
        DRAIN_SPARSE,
        DRAIN_RUNS
    } drain_style_t;

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic        s_mode            = MODE_WRITE;
    logic [3:0]  s_addressing_mode = AM_IMM;
    logic [15:0] s_pc              = '0;
    logic [7:0]  s_index_x         = '0;
    logic [7:0]  s_index_y         = '0;
    logic [15:0] s_write_address   = '0;
    logic [7:0]  s_write_data      = '0;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [15:0] m_effective_address;
    logic [15:0] m_next_pc;
    logic        m_mode_error;
    int          fail_count;
    int          pending;

    // stimulus-side view of memory, used only to keep every read on written bytes
    logic [7:0]  shadow_mem [0:65535];
    bit          shadow_valid [0:65535];
    int          sent_count  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;

    always #6 aclk = ~aclk;

    operand_address_resolver u_dut (.*);

    operand_address_checker u_check (.*);

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int operand_count(input logic [3:0] am);
        case (am)
            AM_ABS, AM_ABSX, AM_ABSY, AM_IND: return 2;
            AM_ZP, AM_ZPX, AM_ZPY, AM_INDX, AM_INDY: return 1;
            default: return 0;
        endcase
    endfunction

    task automatic send_request(
        input logic        mode,
        input logic [3:0]  am,
        input logic [15:0] pc,
        input logic [7:0]  ix,
        input logic [7:0]  iy,
        input logic [15:0] wa,
        input logic [7:0]  wd
    );
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_valid           <= 1'b1;
        s_mode            <= mode;
        s_addressing_mode <= am;
        s_pc              <= pc;
        s_index_x         <= ix;
        s_index_y         <= iy;
        s_write_address   <= wa;
        s_write_data      <= wd;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        sent_count++;
    endtask

    task automatic put_byte(input logic [15:0] addr, input logic [7:0] data);
        shadow_mem[addr]   = data;
        shadow_valid[addr] = 1'b1;
        send_request(MODE_WRITE, 4'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     addr, data);
    endtask

    task automatic need_byte(input logic [15:0] addr);
        if (!shadow_valid[addr])
            put_byte(addr, pick_byte());
    endtask

    // write whatever the resolve will read that is still unwritten, then send it
    task automatic resolve_request(
        input logic [3:0]  am,
        input logic [15:0] pc,
        input logic [7:0]  ix,
        input logic [7:0]  iy
    );
        logic [15:0] ptr;
        logic [7:0]  zp;
        if (operand_count(am) > 0)
            need_byte(pc);
        if (operand_count(am) > 1)
            need_byte(pc + 16'd1);
        ptr = {shadow_mem[pc + 16'd1], shadow_mem[pc]};
        case (am)
            AM_IND: begin
                need_byte(ptr);
                need_byte({ptr[15:8], ptr[7:0] + 8'd1});
            end
            AM_INDX, AM_INDY: begin
                zp = (am == AM_INDX) ? shadow_mem[pc] + ix : shadow_mem[pc];
                need_byte({8'h00, zp});
                need_byte({8'h00, zp + 8'd1});
            end
            default: ;
        endcase
        send_request(MODE_RESOLVE, am, pc, ix, iy, 16'($urandom), 8'($urandom));
    endtask

    task automatic random_resolve();
        logic [3:0]  am;
        logic [15:0] pc;
        am = 4'($urandom_range(AM_IMM, AM_REL));
        case ($urandom_range(0, 9))
            0: pc = 16'hFFFF;
            1, 2, 3: pc = 16'h0200 + 16'($urandom_range(0, 31));
            4: pc = {8'($urandom), 8'hFF};
            5: pc = {8'h00, 8'($urandom)};
            default: pc = 16'($urandom);
        endcase
        // often refresh the operand bytes so page-edge values keep turning up
        if ($urandom_range(0, 1)) begin
            if (operand_count(am) > 0)
                put_byte(pc, pick_byte());
            if (operand_count(am) > 1)
                put_byte(pc + 16'd1, pick_byte());
        end
        resolve_request(am, pc, pick_byte(), pick_byte());
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        put_byte(16'hFFFF, 8'h34);
        put_byte(16'h0000, 8'h12);
        put_byte(16'h8000, 8'hFF);
        put_byte(16'h8001, 8'hFF);
        put_byte(16'hFF00, 8'hAB);
        put_byte(16'h00FF, 8'hCD);
        resolve_request(AM_ABS, 16'hFFFF, 8'h00, 8'h00);
        resolve_request(AM_IMM, 16'hFFFF, 8'hFF, 8'hFF);
        resolve_request(AM_REL, 16'h1234, 8'h55, 8'hAA);
        resolve_request(AM_ZP, 16'hFFFF, 8'h00, 8'hFF);
        resolve_request(AM_ZPX, 16'h8000, 8'hFF, 8'h00);
        resolve_request(AM_ZPY, 16'h8000, 8'h00, 8'h01);
        resolve_request(AM_ABSX, 16'h8000, 8'hFF, 8'h00);
        resolve_request(AM_ABSY, 16'h8000, 8'h00, 8'h01);
        resolve_request(AM_IND, 16'h8000, 8'h00, 8'h00);
        resolve_request(AM_INDX, 16'h8000, 8'h00, 8'h00);
        resolve_request(AM_INDY, 16'h8000, 8'h00, 8'hFF);
        resolve_request(AM_NONE, 16'hFFFF, 8'hFF, 8'hFF);
        resolve_request(AM_LAST_CODE, 16'h0000, 8'h00, 8'h00);

        while (sent_count < TARGET_REQUESTS) begin
            case ($urandom_range(0, 9))
                0: put_byte(16'($urandom), 8'($urandom));
                1: resolve_request(4'($urandom_range(AM_NONE, AM_LAST_CODE)), 16'($urandom),
                                   8'($urandom), 8'($urandom));
                default: random_resolve();
            endcase
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : result_drain
        drain_style_t style;
        int           phase_left;
        int           hold_count;
        bit           hold_done;
        style      = DRAIN_FREE;
        phase_left = 0;
        hold_done  = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            // hold off long enough for the block to back up into its input
            if (!hold_done && sent_count >= 150) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++)
                    @(posedge aclk);
            end
            if (phase_left == 0) begin
                style      = drain_style_t'($urandom_range(0, 3));
                phase_left = $urandom_range(4, 64);
            end
            phase_left--;
            case (style)
                DRAIN_FREE:   m_ready <= 1'b1;
                DRAIN_HALF:   m_ready <= 1'($urandom);
                DRAIN_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:      m_ready <= phase_left[2];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
